// File: design/websocket_frame_deframer_core_macros.svh
// Assertion macros for the WebSocket deframer core.
// Standalone header; the assertion bodies drop out when SYNTHESIS is defined.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define WSD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");
`define WSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");
`else
`define WSD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define WSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/wsd_pkg.sv
// Shared types and constants for the WebSocket deframer core.
// No dependencies.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CLOSED  = 3'd5
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;

   localparam logic [3:0] OP_CLOSE = 4'h8;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // down counters hold "bytes left minus one"
   localparam logic [2:0] CNT_EXT16 = 3'd1;
   localparam logic [2:0] CNT_EXT64 = 3'd7;
   localparam logic [2:0] CNT_KEY   = 3'd3;

endpackage

// File: design/websocket_frame_deframer_core.sv
// WebSocket client-to-server deframer: takes one stream byte per word and
// returns unmasked payload bytes and frame events. Depends on wsd_pkg and the macros header.
//
// The core accepts one byte per clock cycle while req_ready is high; a result appears
// on rsp_valid in the cycle after the causing byte is accepted. Header parsing, the
// 64-bit remaining-length decrement and the unmask XOR all happen between the
// frame state registers and a single output register, so req_ready only drops
// while that output register holds a word the consumer has not taken. Header
// bytes give no word except the one that rejects an unmasked frame or ends the
// header of an empty frame. After a close frame ends or a frame is rejected,
// bytes are still taken but dropped until reset. There is no startup sweep.
module websocket_frame_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [3:0] rsp_opcode,
   output logic       rsp_fin,
   output logic [2:0] rsp_reserved_bits,
   output logic       rsp_last_of_frame,
   output logic       rsp_now_closed,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        require_mask_ff;
   logic [2:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_idx_ff, key_idx_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic [2:0]  rsv_ff, rsv_in;
   logic        masked_ff, masked_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff;
   logic [7:0]  pbyte_ff;
   logic [3:0]  op_out_ff;
   logic        fin_out_ff;
   logic [2:0]  rsv_out_ff;
   logic        last_ff;
   logic        closed_ff;

   logic        accept;
   logic [6:0]  len7;
   logic        is_ext;
   logic        reject;
   logic        is_close;
   logic [63:0] rem_shift;
   logic [7:0]  key_byte;

   logic        emit;
   logic [1:0]  emit_kind;
   logic [7:0]  emit_pbyte;
   logic        emit_last;
   logic        emit_closed;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign len7      = req_data_byte[6:0];
   assign is_ext    = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
   assign reject    = !req_data_byte[7] && require_mask_ff;
   assign is_close  = (opcode_ff == OP_CLOSE);
   assign rem_shift = {rem_ff[55:0], req_data_byte};

   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HDR0: phase_in = PH_HDR1;
            PH_HDR1: begin
               if (reject)
                  phase_in = PH_CLOSED;
               else if (is_ext)
                  phase_in = PH_EXTLEN;
               else if (req_data_byte[7])
                  phase_in = PH_KEY;
               else if (len7 == 7'd0)
                  phase_in = is_close ? PH_CLOSED : PH_HDR0;
               else
                  phase_in = PH_PAYLOAD;
            end
            PH_EXTLEN: begin
               if (cnt_ff == 3'd0) begin
                  if (masked_ff)
                     phase_in = PH_KEY;
                  else if (rem_shift == 64'd0)
                     phase_in = is_close ? PH_CLOSED : PH_HDR0;
                  else
                     phase_in = PH_PAYLOAD;
               end
            end
            PH_KEY: begin
               if (cnt_ff == 3'd0) begin
                  if (rem_ff == 64'd0)
                     phase_in = is_close ? PH_CLOSED : PH_HDR0;
                  else
                     phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (rem_ff == 64'd1)
                  phase_in = is_close ? PH_CLOSED : PH_HDR0;
            end
            PH_CLOSED: phase_in = PH_CLOSED;
            default:   phase_in = PH_CLOSED;
         endcase
      end
   end

   // frame registers and result word
   always_comb begin
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      key_in      = key_ff;
      key_idx_in  = key_idx_ff;
      opcode_in   = opcode_ff;
      fin_in      = fin_ff;
      rsv_in      = rsv_ff;
      masked_in   = masked_ff;
      emit        = 1'b0;
      emit_kind   = KIND_PAYLOAD;
      emit_pbyte  = 8'd0;
      emit_last   = 1'b0;
      emit_closed = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = req_data_byte[7];
               rsv_in    = req_data_byte[6:4];
               opcode_in = req_data_byte[3:0];
            end
            PH_HDR1: begin
               masked_in  = req_data_byte[7];
               key_idx_in = 2'd0;
               if (reject) begin
                  emit        = 1'b1;
                  emit_kind   = KIND_REJECT;
                  emit_last   = 1'b1;
                  emit_closed = 1'b1;
               end else if (len7 == LEN_EXT16) begin
                  cnt_in = CNT_EXT16;
                  rem_in = 64'd0;
               end else if (len7 == LEN_EXT64) begin
                  cnt_in = CNT_EXT64;
                  rem_in = 64'd0;
               end else begin
                  rem_in = {57'd0, len7};
                  if (req_data_byte[7]) begin
                     cnt_in = CNT_KEY;
                  end else if (len7 == 7'd0) begin
                     emit        = 1'b1;
                     emit_kind   = KIND_EMPTY;
                     emit_last   = 1'b1;
                     emit_closed = is_close;
                  end
               end
            end
            PH_EXTLEN: begin
               rem_in = rem_shift;
               cnt_in = cnt_ff - 3'd1;
               if (cnt_ff == 3'd0) begin
                  if (masked_ff) begin
                     cnt_in = CNT_KEY;
                  end else if (rem_shift == 64'd0) begin
                     emit        = 1'b1;
                     emit_kind   = KIND_EMPTY;
                     emit_last   = 1'b1;
                     emit_closed = is_close;
                  end
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], req_data_byte};
               cnt_in = cnt_ff - 3'd1;
               if ((cnt_ff == 3'd0) && (rem_ff == 64'd0)) begin
                  emit        = 1'b1;
                  emit_kind   = KIND_EMPTY;
                  emit_last   = 1'b1;
                  emit_closed = is_close;
               end
            end
            PH_PAYLOAD: begin
               emit        = 1'b1;
               emit_kind   = KIND_PAYLOAD;
               emit_pbyte  = req_data_byte ^ (masked_ff ? key_byte : 8'd0);
               emit_last   = (rem_ff == 64'd1);
               emit_closed = (rem_ff == 64'd1) && is_close;
               rem_in      = rem_ff - 64'd1;
               key_idx_in  = key_idx_ff + 2'd1;
            end
            default: begin
               // closed: byte is dropped
            end
         endcase
      end
   end

   assign rsp_valid_in = (accept && emit) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         require_mask_ff <= 1'b1;
         cnt_ff          <= 3'd0;
         rem_ff          <= 64'd0;
         key_ff          <= 32'd0;
         key_idx_ff      <= 2'd0;
         opcode_ff       <= 4'd0;
         fin_ff          <= 1'b0;
         rsv_ff          <= 3'd0;
         masked_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         if (csr_wr_en)
            require_mask_ff <= csr_wr_data;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         key_ff       <= key_in;
         key_idx_ff   <= key_idx_in;
         opcode_ff    <= opcode_in;
         fin_ff       <= fin_in;
         rsv_ff       <= rsv_in;
         masked_ff    <= masked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff    <= emit_kind;
         pbyte_ff   <= emit_pbyte;
         op_out_ff  <= opcode_ff;
         fin_out_ff <= fin_ff;
         rsv_out_ff <= rsv_ff;
         last_ff    <= emit_last;
         closed_ff  <= emit_closed;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_payload_byte  = pbyte_ff;
   assign rsp_opcode        = op_out_ff;
   assign rsp_fin           = fin_out_ff;
   assign rsp_reserved_bits = rsv_out_ff;
   assign rsp_last_of_frame = last_ff;
   assign rsp_now_closed    = closed_ff;

`include "websocket_frame_deframer_core_macros.svh"

   `WSD_ASSERT_IMPLIES(a_event_is_last, clock, reset, rsp_valid_ff && (kind_ff != KIND_PAYLOAD), last_ff)
   `WSD_ASSERT_IMPLIES(a_event_no_data, clock, reset, rsp_valid_ff && (kind_ff != KIND_PAYLOAD), pbyte_ff == 8'd0)
   `WSD_ASSERT_IMPLIES(a_closed_word, clock, reset, rsp_valid_ff && closed_ff, phase_ff == PH_CLOSED)
   `WSD_ASSERT_NEXT(a_closed_sticky, clock, reset, phase_ff == PH_CLOSED, phase_ff == PH_CLOSED)

endmodule
